>>> src/assert_macros.svh
// shared assertion macros for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lbl failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lbl failed");

`endif

>>> src/ddvsw_pkg.sv
`default_nettype none
package ddvsw_pkg;

   localparam int WIPER_W = 9;
   localparam int INDEX_W = 5;
   localparam int TABLE_SIZE = 32;
   localparam int WORD_W = 32;

   localparam logic [7:0] MIN_REVISION = 8'hA2;
   localparam logic [7:0] RESET_REVISION = 8'd162;
   localparam logic [WORD_W-1:0] RIGHT_ADDR_BIT = 32'h0000_1000;

   // register indexes
   localparam logic REG_BOARD_REVISION = 1'b0;
   localparam logic REG_AMP_ENABLE = 1'b1;

   // looked-up wiper value handed to the serializer
   typedef struct packed {
      logic               valid;
      logic [WIPER_W-1:0] wiper;
   } stage_type;

   function automatic logic [WIPER_W-1:0] atten(input logic [INDEX_W-1:0] idx);
      logic [WIPER_W-1:0] w;
      case (idx)
         5'd0:  w = 9'd0;
         5'd1:  w = 9'd2;
         5'd2:  w = 9'd2;
         5'd3:  w = 9'd3;
         5'd4:  w = 9'd3;
         5'd5:  w = 9'd4;
         5'd6:  w = 9'd5;
         5'd7:  w = 9'd5;
         5'd8:  w = 9'd6;
         5'd9:  w = 9'd7;
         5'd10: w = 9'd9;
         5'd11: w = 9'd10;
         5'd12: w = 9'd12;
         5'd13: w = 9'd14;
         5'd14: w = 9'd17;
         5'd15: w = 9'd19;
         5'd16: w = 9'd23;
         5'd17: w = 9'd27;
         5'd18: w = 9'd31;
         5'd19: w = 9'd37;
         5'd20: w = 9'd43;
         5'd21: w = 9'd51;
         5'd22: w = 9'd60;
         5'd23: w = 9'd71;
         5'd24: w = 9'd83;
         5'd25: w = 9'd97;
         5'd26: w = 9'd114;
         5'd27: w = 9'd134;
         5'd28: w = 9'd158;
         5'd29: w = 9'd185;
         5'd30: w = 9'd218;
         default: w = 9'd256;
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

>>> src/dual_digipot_volume_spi_writer.sv
// a word passes the map's stage, serializer word and output registers before
// its first bit shows; two frames of FRAME_BITS bits follow, one bit per cycle
//    unless rsp_ready stalls, and the next word is held in the map's stage meanwhile
// words on boards below revision 0xA2 are taken and give no bits
// reset clears all valid flags, board revision to 0xA2 and amp enable to 1
`default_nettype none
module dual_digipot_volume_spi_writer #(
   parameter int TABLE_ENTRIES = 32,
   parameter int FRAME_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_volume,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_data_bit,
   output logic             rsp_channel,
   output logic [3:0]       rsp_bit_position,
   output logic             rsp_frame_end,
   output logic             rsp_last,
   output logic             rsp_amp_on,
   input  wire logic        csr_wen,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata
);

   logic [7:0]              rev_ff;
   logic                    amp_ff;
   logic                    take;
   ddvsw_pkg::stage_type    stage;

   always_ff @(posedge clock) begin
      if (reset) begin
         rev_ff <= ddvsw_pkg::RESET_REVISION;
         amp_ff <= 1'b1;
      end else if (csr_wen) begin
         case (csr_index)
            ddvsw_pkg::REG_BOARD_REVISION: rev_ff <= csr_wdata;
            ddvsw_pkg::REG_AMP_ENABLE:     amp_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   ddvsw_map #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_map (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_volume     (req_volume),
      .board_revision (rev_ff),
      .take           (take),
      .stage          (stage)
   );

   ddvsw_ser #(
      .FRAME_BITS(FRAME_BITS)
   ) u_ser (
      .clock            (clock),
      .reset            (reset),
      .stage            (stage),
      .take             (take),
      .amp_enable       (amp_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data_bit     (rsp_data_bit),
      .rsp_channel      (rsp_channel),
      .rsp_bit_position (rsp_bit_position),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_last         (rsp_last),
      .rsp_amp_on       (rsp_amp_on)
   );

endmodule
`default_nettype wire

>>> src/ddvsw_map.sv
`default_nettype none
module ddvsw_map #(
   parameter int TABLE_ENTRIES = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_volume,
   input  wire logic [7:0]            board_revision,
   input  wire logic                  take,
   output ddvsw_pkg::stage_type       stage
);

   logic                              valid_ff, valid_in;
   logic [ddvsw_pkg::WIPER_W-1:0]     wiper_ff;
   logic [15:0]                       prod;
   logic [7:0]                        idx_full;
   logic [ddvsw_pkg::INDEX_W-1:0]     idx;

   assign req_ready = !valid_ff || take;

   // scaled table index, saturated at the last entry
   assign prod = 16'(req_volume) * 16'(TABLE_ENTRIES);
   assign idx_full = prod[15:8];
   assign idx = (idx_full >= 8'(ddvsw_pkg::TABLE_SIZE)) ?
                ddvsw_pkg::INDEX_W'(ddvsw_pkg::TABLE_SIZE - 1) :
                idx_full[ddvsw_pkg::INDEX_W-1:0];

   // old boards swallow the word without any frame
   assign valid_in = req_valid && (board_revision >= ddvsw_pkg::MIN_REVISION);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         wiper_ff <= ddvsw_pkg::atten(idx);
      end
   end

   assign stage.valid = valid_ff;
   assign stage.wiper = wiper_ff;

endmodule
`default_nettype wire

>>> src/ddvsw_ser.sv
`default_nettype none
module ddvsw_ser #(
   parameter int FRAME_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ddvsw_pkg::stage_type  stage,
   output logic                       take,
   input  wire logic                  amp_enable,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_data_bit,
   output logic                       rsp_channel,
   output logic [3:0]                 rsp_bit_position,
   output logic                       rsp_frame_end,
   output logic                       rsp_last,
   output logic                       rsp_amp_on
);

   localparam int PW = $clog2(FRAME_BITS);
   localparam logic [PW-1:0] LAST_POS = PW'(FRAME_BITS - 1);

   logic                              active_ff, active_in;
   logic                              ch_ff, ch_in;
   logic [PW-1:0]                     pos_ff, pos_in;
   logic [ddvsw_pkg::WIPER_W-1:0]     word_ff, word_in;
   logic                              advance, is_last;
   logic [ddvsw_pkg::WORD_W-1:0]      frame32;
   logic [FRAME_BITS-1:0]             frame;
   logic [4:0]                        pos_wide;

   logic                              valid_ff;
   logic                              data_ff, chan_ff, fend_ff, last_ff, amp_ff;
   logic [3:0]                        bpos_ff;

   assign advance = !valid_ff || rsp_ready;
   assign is_last = ch_ff && (pos_ff == '0);
   // next word loads as the final bit of the current one moves out
   assign take = stage.valid && (!active_ff || (advance && is_last));

   assign frame32 = ddvsw_pkg::WORD_W'(word_ff) |
                    (ch_ff ? ddvsw_pkg::RIGHT_ADDR_BIT : '0);
   assign frame = frame32[FRAME_BITS-1:0];
   assign pos_wide = 5'(pos_ff);

   always_comb begin
      active_in = active_ff;
      ch_in = ch_ff;
      pos_in = pos_ff;
      word_in = word_ff;
      if (advance && active_ff) begin
         if (pos_ff == '0) begin
            if (ch_ff) begin
               active_in = 1'b0;
            end else begin
               ch_in = 1'b1;
               pos_in = LAST_POS;
            end
         end else begin
            pos_in = pos_ff - PW'(1);
         end
      end
      if (take) begin
         active_in = 1'b1;
         ch_in = 1'b0;
         pos_in = LAST_POS;
         word_in = stage.wiper;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         if (advance) begin
            valid_ff <= active_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      ch_ff <= ch_in;
      pos_ff <= pos_in;
      word_ff <= word_in;
      if (advance) begin
         data_ff <= frame[pos_ff];
         chan_ff <= ch_ff;
         bpos_ff <= pos_wide[3:0];
         fend_ff <= (pos_ff == '0);
         last_ff <= is_last;
         amp_ff <= amp_enable;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data_bit = data_ff;
   assign rsp_channel = chan_ff;
   assign rsp_bit_position = bpos_ff;
   assign rsp_frame_end = fend_ff;
   assign rsp_last = last_ff;
   assign rsp_amp_on = amp_ff;

endmodule
`default_nettype wire

>>> src/ddvsw_chk.sv
`default_nettype none
`include "assert_macros.svh"
module ddvsw_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [7:0]  req_volume,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_data_bit,
   input wire logic        rsp_channel,
   input wire logic [3:0]  rsp_bit_position,
   input wire logic        rsp_frame_end,
   input wire logic        rsp_last,
   input wire logic        rsp_amp_on,
   input wire logic        csr_wen,
   input wire logic        csr_index,
   input wire logic [7:0]  csr_wdata
);

   // last bit only ends the right frame
   `ASSERT_IMP(a_last_right, clock, reset, rsp_valid && rsp_last, rsp_frame_end && rsp_channel)

   // a frame runs on without gaps, counting down
   `ASSERT_NXT(a_pos_down, clock, reset, rsp_valid && rsp_ready && !rsp_frame_end, rsp_valid && (rsp_bit_position == 4'($past(rsp_bit_position) - 4'd1)))

   // channel holds inside a frame
   `ASSERT_NXT(a_chan_hold, clock, reset, rsp_valid && rsp_ready && !rsp_frame_end, rsp_channel == $past(rsp_channel))

   // stalled output bit holds with its position and channel
   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data_bit) && $stable(rsp_bit_position) && $stable(rsp_channel))

endmodule

bind dual_digipot_volume_spi_writer ddvsw_chk u_chk (.*);
`default_nettype wire
